/* sv/bclte_pkg.sv */
// Shared types, codes and default sizes for the block cache tag engine.
package bclte_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_ENTRIES   = 32;
  localparam int DEF_ADDR_BITS = 48;
  localparam int DEF_MAX_RANGE = 8;

  // Fixed widths of the beat fields.
  localparam int BLK_ADDR_W = 48;
  localparam int SLOT_W     = 5;
  localparam int PIN_W      = 16;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  // Request codes.
  localparam logic [1:0] REQ_GET     = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_DIRTY   = 2'd2;
  localparam logic [1:0] REQ_INVAL   = 2'd3;

  // Response status codes.
  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2,
    STAT_DONE = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_ONE_RD,
    ST_ONE_WR,
    ST_REPLY
  } state_t;

  // Request beat.
  typedef struct packed {
    logic [1:0]            req_type;
    logic [BLK_ADDR_W-1:0] block_addr;
    logic [3:0]            block_count;
    logic [SLOT_W-1:0]     slot;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_W-1:0]     slot_out;
    logic                  writeback_valid;
    logic [BLK_ADDR_W-1:0] writeback_addr;
  } rsp_t;

endpackage

/* sv/bclte_ram.sv */
// Single port write, single port read memory with a registered read.
module bclte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/block_cache_lru_tag_engine_top.sv */
// Top level of the block cache tag and LRU replacement engine.
//
// Requests arrive on req_valid/req_ready/req and each gives exactly one
// response beat on rsp_valid/rsp_ready/rsp. All entry state (tag, valid,
// dirty, pin count, recency rank) lives in one memory with a registered read.
// A get walks every entry once to find a hit or the oldest unpinned victim,
// then, if it found either, walks every entry again to age the ranks and
// to pin the hit or retag the victim. An invalidate is one walk; release and
// mark dirty on an in-range slot are one read and one write. Each walk reads
// one entry per cycle through the memory read port.
// One request is worked on at a time; req_ready is high only between
// requests. The response sits in an output register, so the next request is
// taken while a finished response still waits; a stalled receiver holds the
// engine only once a second response is ready.
// After reset the engine writes the reset value into every entry (rank i in
// entry i, everything else clear) with req_ready low.
module block_cache_lru_tag_engine_top #(
  parameter int ENTRIES   = bclte_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = bclte_pkg::DEF_ADDR_BITS,
  parameter int MAX_RANGE = bclte_pkg::DEF_MAX_RANGE
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bclte_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bclte_pkg::rsp_t rsp
);
  import bclte_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = ADDR_BITS;
  localparam int LW = 7;

  typedef struct packed {
    logic [AW-1:0]    tag;
    logic             valid;
    logic             dirty;
    logic [PIN_W-1:0] pin;
    logic [IW-1:0]    rank;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  logic [CW-1:0] cnt;
  logic          rd_v;
  logic [IW-1:0] rd_i;

  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [LW-1:0] lim_q;
  logic [IW-1:0] slot_q;

  logic          hit_f;
  logic [IW-1:0] hit_i;
  logic [IW-1:0] hit_rank;
  logic          vic_f;
  logic [IW-1:0] vic_i;
  logic [IW-1:0] vic_rank;
  logic [AW-1:0] vic_tag;
  logic          vic_wb;

  logic [IW-1:0] tgt_i;
  logic [IW-1:0] tgt_rank;
  logic          tgt_hit;
  rsp_t          res_q;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  entry_t        e;

  logic          scan_rd;
  logic          scan_done;
  logic          accept;
  logic          rsp_load;
  logic          slot_ok;
  logic [63:0]   addr_wide;
  logic [AW-1:0] addr_in;
  logic [LW-1:0] lim_in;
  logic [63:0]   vic_tag_wide;
  logic [AW-1:0] diff;
  logic          tag_hit;
  logic          in_range;
  logic          vic_better;

  // Entry store.
  bclte_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign e = entry_t'(mem_rdata);

  // Request decode and handshake.
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_load  = (state == ST_REPLY) && (!rsp_valid || rsp_ready);
  assign slot_ok   = 32'(req.slot) < 32'(ENTRIES);
  assign addr_wide = 64'(req.block_addr);
  assign addr_in   = addr_wide[AW-1:0];
  assign lim_in    = (LW'(req.block_count) > LW'(MAX_RANGE)) ? LW'(MAX_RANGE)
                                                             : LW'(req.block_count);
  assign vic_tag_wide = 64'(vic_tag);

  // Walk control: one read issued per cycle, its data evaluated in the cycle after the read.
  assign scan_rd   = ((state == ST_SCAN) || (state == ST_SWEEP)) && (cnt != CW'(ENTRIES));
  assign scan_done = (cnt == CW'(ENTRIES)) && !rd_v;
  assign mem_raddr = (state == ST_ONE_RD) ? slot_q : cnt[IW-1:0];

  // Per-entry compares on the read data.
  assign diff       = e.tag - addr_q;
  assign tag_hit    = e.valid && (e.tag == addr_q);
  assign in_range   = e.valid && (diff < AW'(lim_q));
  assign vic_better = (e.pin == '0) && (!vic_f || (e.rank < vic_rank));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt == CW'(ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.req_type) inside
            REQ_GET, REQ_INVAL: state_next = ST_SCAN;
            default:            state_next = slot_ok ? ST_ONE_RD : ST_REPLY;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if ((op_q == REQ_GET) && (hit_f || vic_f)) state_next = ST_SWEEP;
          else                                        state_next = ST_REPLY;
        end
      end
      ST_SWEEP: begin
        if (scan_done) state_next = ST_REPLY;
      end
      ST_ONE_RD: state_next = ST_ONE_WR;
      ST_ONE_WR: state_next = ST_REPLY;
      ST_REPLY: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Memory write decode: reset fill in init, otherwise read-modify-write of the entry just read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_i;
    mem_wdata = e;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = '0;
        mem_wdata.rank = cnt[IW-1:0];
      end
      ST_SCAN: begin
        if (rd_v && (op_q == REQ_INVAL) && in_range) begin
          mem_we          = 1'b1;
          mem_wdata.valid = 1'b0;
          mem_wdata.dirty = 1'b0;
        end
      end
      ST_SWEEP: begin
        if (rd_v) begin
          mem_we = 1'b1;
          if (e.rank > tgt_rank) mem_wdata.rank = e.rank - 1'b1;
          if (rd_i == tgt_i) begin
            mem_wdata.rank = IW'(ENTRIES - 1);
            if (tgt_hit) begin
              if (e.pin != PIN_MAX) mem_wdata.pin = e.pin + 1'b1;
            end else begin
              mem_wdata.tag   = addr_q;
              mem_wdata.valid = 1'b1;
              mem_wdata.dirty = 1'b0;
              mem_wdata.pin   = PIN_W'(1);
            end
          end
        end
      end
      ST_ONE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        if (op_q == REQ_RELEASE) begin
          if (e.pin != '0) mem_wdata.pin = e.pin - 1'b1;
        end else begin
          mem_wdata.dirty = 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // State, walk counter and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= scan_rd;
      if (state_next != state) cnt <= '0;
      else if ((state == ST_INIT) || scan_rd) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_i <= cnt[IW-1:0];
  end

  // Request capture, search results and the pending response.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f <= 1'b0;
      vic_f <= 1'b0;
    end else if (accept) begin
      op_q   <= req.req_type;
      addr_q <= addr_in;
      lim_q  <= lim_in;
      slot_q <= IW'(req.slot);
      hit_f  <= 1'b0;
      vic_f  <= 1'b0;
      res_q  <= '{status: STAT_DONE, slot_out: '0, writeback_valid: 1'b0,
                  writeback_addr: '0};
    end else if (state == ST_SCAN) begin
      if (rd_v && (op_q == REQ_GET)) begin
        if (tag_hit) begin
          hit_f    <= 1'b1;
          hit_i    <= rd_i;
          hit_rank <= e.rank;
        end
        if (vic_better) begin
          vic_f    <= 1'b1;
          vic_i    <= rd_i;
          vic_rank <= e.rank;
          vic_tag  <= e.tag;
          vic_wb   <= e.valid && e.dirty;
        end
      end
      if (scan_done && (op_q == REQ_GET)) begin
        if (hit_f) begin
          tgt_i          <= hit_i;
          tgt_rank       <= hit_rank;
          tgt_hit        <= 1'b1;
          res_q.status   <= STAT_HIT;
          res_q.slot_out <= SLOT_W'(hit_i);
        end else if (vic_f) begin
          tgt_i                 <= vic_i;
          tgt_rank              <= vic_rank;
          tgt_hit               <= 1'b0;
          res_q.status          <= STAT_MISS;
          res_q.slot_out        <= SLOT_W'(vic_i);
          res_q.writeback_valid <= vic_wb;
          res_q.writeback_addr  <= vic_wb ? vic_tag_wide[BLK_ADDR_W-1:0] : '0;
        end else begin
          res_q.status <= STAT_FULL;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= res_q;
  end

  // A walk never writes the entry it is reading in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && scan_rd) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one entry during a walk");

  // A response only appears after the reply state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_REPLY))
    else $error("response raised outside the reply state");

  // Writebacks come only with a miss allocation.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.writeback_valid) |-> (rsp.status == STAT_MISS))
    else $error("writeback ordered without a miss");

endmodule

/* verif/block_cache_lru_tag_engine_top_test.sv */
// Self-checking test of the block cache tag engine: directed table, a pin-all fill, then random traffic.
module block_cache_lru_tag_engine_top_test;
  import bclte_pkg::*;

  localparam int NUM_ENTRIES = DEF_ENTRIES;
  localparam int RANGE_MAX   = DEF_MAX_RANGE;
  localparam int RANDOM_REQS = 650;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  block_cache_lru_tag_engine_top u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the entry state.
  logic [BLK_ADDR_W-1:0] shadow_tag [NUM_ENTRIES];
  logic                  shadow_valid [NUM_ENTRIES];
  logic                  shadow_dirty [NUM_ENTRIES];
  logic [PIN_W-1:0]      shadow_pins [NUM_ENTRIES];
  int unsigned           shadow_rank [NUM_ENTRIES];

  rsp_t pending_rsps[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  logic [BLK_ADDR_W-1:0] addr_pool [16];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_pins[i] = '0;
      shadow_rank[i] = i;
    end
  endfunction

  function automatic void promote_entry(input int idx);
    int unsigned r;
    r = shadow_rank[idx];
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_rank[i] > r) shadow_rank[i]--;
    shadow_rank[idx] = NUM_ENTRIES - 1;
  endfunction

  function automatic int lookup_tag(input logic [BLK_ADDR_W-1:0] a);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_valid[i] && shadow_tag[i] == a) return i;
    return -1;
  endfunction

  // Applies one request to the shadow state and returns the expected response.
  function automatic rsp_t cache_response(input req_t r);
    rsp_t o;
    int   e;
    int   n;
    o = '0;
    o.status = STAT_DONE;
    case (r.req_type)
      REQ_GET: begin
        e = lookup_tag(r.block_addr);
        if (e >= 0) begin
          if (shadow_pins[e] != PIN_MAX) shadow_pins[e]++;
          promote_entry(e);
          o.status = STAT_HIT;
          o.slot_out = SLOT_W'(e);
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_pins[i] == 0 && (e < 0 || shadow_rank[i] < shadow_rank[e])) e = i;
          if (e < 0) begin
            o.status = STAT_FULL;
          end else begin
            if (shadow_valid[e] && shadow_dirty[e]) begin
              o.writeback_valid = 1'b1;
              o.writeback_addr = shadow_tag[e];
            end
            shadow_tag[e] = r.block_addr;
            shadow_valid[e] = 1'b1;
            shadow_dirty[e] = 1'b0;
            shadow_pins[e] = PIN_W'(1);
            promote_entry(e);
            o.status = STAT_MISS;
            o.slot_out = SLOT_W'(e);
          end
        end
      end
      REQ_RELEASE: begin
        if (r.slot < NUM_ENTRIES && shadow_pins[r.slot] != 0) shadow_pins[r.slot]--;
      end
      REQ_DIRTY: begin
        if (r.slot < NUM_ENTRIES) shadow_dirty[r.slot] = 1'b1;
      end
      default: begin
        n = (r.block_count > RANGE_MAX) ? RANGE_MAX : int'(r.block_count);
        for (int k = 0; k < n; k++) begin
          e = lookup_tag(r.block_addr + BLK_ADDR_W'(k));
          if (e >= 0) begin
            shadow_valid[e] = 1'b0;
            shadow_dirty[e] = 1'b0;
          end
        end
      end
    endcase
    return o;
  endfunction

  // Directed rows; check_row marks a response that is typed in.
  typedef struct {
    req_t beat;
    bit   check_row;
    rsp_t want;
  } stim_row_t;

  function automatic req_t make_req(input logic [1:0] t, input logic [BLK_ADDR_W-1:0] a,
                                    input logic [3:0] c, input logic [SLOT_W-1:0] s);
    req_t r;
    r.req_type = t;
    r.block_addr = a;
    r.block_count = c;
    r.slot = s;
    return r;
  endfunction

  function automatic rsp_t make_rsp(input status_e st, input logic [SLOT_W-1:0] s,
                                    input logic wv, input logic [BLK_ADDR_W-1:0] wa);
    rsp_t o;
    o.status = st;
    o.slot_out = s;
    o.writeback_valid = wv;
    o.writeback_addr = wa;
    return o;
  endfunction

  stim_row_t directed_rows[$];

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Holds the beat until it is taken; valid stays up for a following beat.
  task automatic send_beat(input req_t r);
    rsp_t e;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    e = cache_response(r);
    pending_rsps.push_back(e);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every expected response has come back.
  task automatic drain_rsps();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  // Random request, gets being the most common, over a small address pool so hits and evictions occur.
  function automatic req_t random_req();
    req_t r;
    int   p;
    p = $urandom_range(0, 99);
    r.block_addr = BLK_ADDR_W'({$urandom, $urandom});
    r.block_count = 4'($urandom_range(0, 15));
    r.slot = SLOT_W'($urandom);
    if (p < 45) begin
      r.req_type = REQ_GET;
      if ($urandom_range(0, 3) != 0) r.block_addr = addr_pool[$urandom_range(0, 15)];
    end else if (p < 75) begin
      r.req_type = REQ_RELEASE;
    end else if (p < 90) begin
      r.req_type = REQ_DIRTY;
    end else begin
      r.req_type = REQ_INVAL;
      if ($urandom_range(0, 1) != 0)
        r.block_addr = addr_pool[$urandom_range(0, 15)] -
                       BLK_ADDR_W'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Response checker with random backpressure.
  initial begin
    rsp_t want;
    int   stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch("unexpected beat", 64'(rsp.status), 64'd0);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.slot_out !== want.slot_out)
            report_mismatch("slot_out", 64'(rsp.slot_out), 64'(want.slot_out));
          if (rsp.writeback_valid !== want.writeback_valid)
            report_mismatch("writeback_valid", 64'(rsp.writeback_valid),
                            64'(want.writeback_valid));
          if (rsp.writeback_addr !== want.writeback_addr)
            report_mismatch("writeback_addr", 64'(rsp.writeback_addr),
                            64'(want.writeback_addr));
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_ready <= 1'b0;
      end else if (cycle_count < 3000 || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
      end else begin
        stall = gap_len();
        rsp_ready <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    stim_row_t row;
    logic [BLK_ADDR_W-1:0] top_addr;
    top_addr = '1;
    shadow_reset();
    for (int i = 0; i < 16; i++) addr_pool[i] = BLK_ADDR_W'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = top_addr;

    // After reset entry 0 is oldest, so the first miss takes slot 0, the next slot 1.
    directed_rows.push_back('{make_req(REQ_GET, '0, '0, '0), 1,
                              make_rsp(STAT_MISS, '0, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_GET, top_addr, '0, '0), 1,
                              make_rsp(STAT_MISS, 5'd1, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_GET, '0, '0, '0), 1,
                              make_rsp(STAT_HIT, '0, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_DIRTY, '0, '0, '0), 1,
                              make_rsp(STAT_DONE, '0, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_DIRTY, '0, '0, 5'd31), 1,
                              make_rsp(STAT_DONE, '0, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_RELEASE, '0, '0, 5'd31), 1,
                              make_rsp(STAT_DONE, '0, 1'b0, '0)});
    // Release at zero, on a never-used slot.
    directed_rows.push_back('{make_req(REQ_RELEASE, '0, '0, 5'd7), 1,
                              make_rsp(STAT_DONE, '0, 1'b0, '0)});
    directed_rows.push_back('{make_req(REQ_RELEASE, top_addr, 4'hf, '0), 0, '0});
    directed_rows.push_back('{make_req(REQ_RELEASE, '0, '0, '0), 0, '0});
    directed_rows.push_back('{make_req(REQ_RELEASE, '0, '0, 5'd1), 0, '0});
    directed_rows.push_back('{make_req(REQ_DIRTY, '0, '0, 5'd1), 0, '0});
    // Range that wraps past the top address, then a long range that is clipped.
    directed_rows.push_back('{make_req(REQ_INVAL, top_addr, 4'd2, '0), 0, '0});
    directed_rows.push_back('{make_req(REQ_INVAL, top_addr - 48'd3, 4'hf, '0), 0, '0});
    directed_rows.push_back('{make_req(REQ_INVAL, 48'h1234, 4'd0, 5'd31), 0, '0});
    directed_rows.push_back('{make_req(REQ_GET, top_addr, '0, 5'd31), 0, '0});
    directed_rows.push_back('{make_req(REQ_DIRTY, '0, '0, 5'd2), 0, '0});
    directed_rows.push_back('{make_req(REQ_RELEASE, '0, '0, 5'd2), 0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.beat);
      if (row.check_row && pending_rsps[$] !== row.want)
        report_mismatch("directed row status", 64'(pending_rsps[$].status),
                        64'(row.want.status));
    end

    // Pin every entry, then keep missing once no victim is left. Dirty some along the way.
    for (int i = 0; i < NUM_ENTRIES + 2; i++) begin
      send_beat(make_req(REQ_GET, 48'h5000 + BLK_ADDR_W'(i), '0, '0));
      if (i % 3 == 0) send_beat(make_req(REQ_DIRTY, '0, '0, SLOT_W'(i)));
    end
    // Unpin everything so random traffic can evict dirty entries.
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_beat(make_req(REQ_RELEASE, '0, '0, SLOT_W'(i)));

    // Hold off until every response is back.
    drain_rsps();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 200 == 0)
        for (int k = 0; k < NUM_ENTRIES; k++)
          send_beat(make_req(REQ_RELEASE, '0, '0, SLOT_W'(k)));
      send_beat(random_req());
      if ((i / 100) % 2 == 1) idle_gap(gap_len());
    end

    drain_rsps();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bclte_pkg.sv
sv/bclte_ram.sv
sv/block_cache_lru_tag_engine_top.sv
verif/block_cache_lru_tag_engine_top_test.sv
